>>> design/lsb_first_bit_field_reader_assert.svh
// Assertion macros shared by the bit field reader modules.
`ifndef LSB_FIRST_BIT_FIELD_READER_ASSERT_SVH
`define LSB_FIRST_BIT_FIELD_READER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/lbfr_pkg.sv
package lbfr_pkg;

   localparam int STORE_WORDS_DEFAULT = 1024;
   localparam int WORD_BITS = 32;
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int KIND_BITS = 2;
   localparam int COUNT_BITS = 6;
   localparam int STATUS_BITS = 2;
   localparam int STEP_BITS = 3;
   localparam int HEAD_BITS = 6;

   localparam logic [KIND_BITS-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_BITS_FIELD = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_PREFIXED = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_VARINT = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERRUN = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic [COUNT_BITS-1:0] MAX_FIELD_BITS = 6'd32;
   localparam logic [COUNT_BITS-1:0] HEAD_FIELD_BITS = 6'd6;
   localparam logic [COUNT_BITS-1:0] BYTE_FIELD_BITS = 6'd8;
   localparam logic [STEP_BITS-1:0] VARINT_LAST_STEP = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXTRACT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic start;
      logic load;
      logic fetch;
      logic extract;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic done;
   } sts_type;

   function automatic logic [COUNT_BITS-1:0] ext_bits(input logic [1:0] sel);
      logic [COUNT_BITS-1:0] bits;
      case (sel)
         2'd1: bits = 6'd4;
         2'd2: bits = 6'd8;
         2'd3: bits = 6'd28;
         default: bits = 6'd0;
      endcase
      return bits;
   endfunction

   function automatic logic [4:0] varint_shift(input logic [STEP_BITS-1:0] step);
      logic [4:0] shamt;
      case (step)
         3'd0: shamt = 5'd0;
         3'd1: shamt = 5'd7;
         3'd2: shamt = 5'd14;
         3'd3: shamt = 5'd21;
         3'd4: shamt = 5'd28;
         default: shamt = 5'd0;
      endcase
      return shamt;
   endfunction

endpackage

>>> design/lbfr_if.sv
interface lbfr_req_if;
   logic valid;
   logic ready;
   logic [lbfr_pkg::KIND_BITS-1:0] kind;
   logic [lbfr_pkg::WORD_BITS-1:0] word;
   logic [lbfr_pkg::COUNT_BITS-1:0] count;

   modport source (output valid, output kind, output word, output count, input ready);
   modport sink (input valid, input kind, input word, input count, output ready);
endinterface

interface lbfr_rsp_if;
   logic valid;
   logic ready;
   logic [lbfr_pkg::WORD_BITS-1:0] value;
   logic [lbfr_pkg::STATUS_BITS-1:0] status;

   modport source (output valid, output value, output status, input ready);
   modport sink (input valid, input value, input status, output ready);
endinterface

>>> design/lbfr_ram.sv
module lbfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> design/lbfr_datapath.sv
`include "lsb_first_bit_field_reader_assert.svh"

module lbfr_datapath #(
   parameter int STORE_WORDS = lbfr_pkg::STORE_WORDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lbfr_pkg::KIND_BITS-1:0]     req_kind,
   input  logic [lbfr_pkg::WORD_BITS-1:0]     req_word,
   input  logic [lbfr_pkg::COUNT_BITS-1:0]    req_count,
   input  lbfr_pkg::cmd_type                  cmd,
   output lbfr_pkg::sts_type                  sts,
   output logic [lbfr_pkg::WORD_BITS-1:0]     rsp_value,
   output logic [lbfr_pkg::STATUS_BITS-1:0]   rsp_status
);

   localparam int AW = $clog2(STORE_WORDS);
   localparam int WB = $clog2(STORE_WORDS + 1);
   localparam int SH = lbfr_pkg::WORD_SHIFT;
   localparam int PB = WB + SH;
   localparam int CB = lbfr_pkg::COUNT_BITS;
   localparam int DW = lbfr_pkg::WORD_BITS;

   logic [lbfr_pkg::KIND_BITS-1:0]   kind_ff, kind_in;
   logic [CB-1:0]                    cnt_ff, cnt_in;
   logic [lbfr_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic [lbfr_pkg::HEAD_BITS-1:0]   head_ff, head_in;
   logic [PB-1:0]                    tp_ff, tp_in;
   logic [PB-1:0]                    pos_ff, pos_in;
   logic [WB-1:0]                    words_ff, words_in;
   logic [DW-1:0]                    value_ff, value_in;
   logic [lbfr_pkg::STATUS_BITS-1:0] status_ff, status_in;

   logic          store_full;
   logic          wr_en;
   logic [AW-1:0] rd_addr_a;
   logic [DW-1:0] rd_data_a;
   logic [DW-1:0] rd_data_b;
   logic [CB-1:0] n;
   logic          straddle;
   logic          avail;
   logic [PB-1:0] loaded;
   logic [PB-1:0] tp_next;
   logic [2*DW-1:0] both;
   logic [DW-1:0] field;
   logic          done;
   logic [DW-1:0] ext_value;
   logic [lbfr_pkg::STATUS_BITS-1:0] ext_status;

   assign store_full = (words_ff >= WB'(STORE_WORDS));
   assign wr_en = cmd.load && !store_full;
   assign rd_addr_a = tp_ff[AW+SH-1:SH];
   assign loaded = {words_ff, {SH{1'b0}}};

   lbfr_ram #(
      .WIDTH(DW),
      .DEPTH(STORE_WORDS)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (words_ff[AW-1:0]),
      .wr_data  (req_word),
      .rd_en    (cmd.fetch),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_a + AW'(1)),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   always_comb begin
      case (kind_ff)
         lbfr_pkg::KIND_BITS_FIELD: n = cnt_ff;
         lbfr_pkg::KIND_PREFIXED: begin
            if (step_ff == '0) begin
               n = lbfr_pkg::HEAD_FIELD_BITS;
            end else begin
               n = lbfr_pkg::ext_bits(head_ff[5:4]);
            end
         end
         lbfr_pkg::KIND_VARINT: n = lbfr_pkg::BYTE_FIELD_BITS;
         default: n = '0;
      endcase
   end

   assign straddle = ({2'b00, tp_ff[SH-1:0]} + {1'b0, n}) > 7'(DW);
   assign avail = ({1'b0, tp_ff} + (PB+1)'(n)) <= {1'b0, loaded};
   assign tp_next = tp_ff + PB'(n);
   assign both = {rd_data_b & {DW{straddle}}, rd_data_a} >> tp_ff[SH-1:0];
   assign field = both[DW-1:0] & ~({DW{1'b1}} << n);

   always_comb begin
      done = 1'b1;
      ext_value = field;
      ext_status = lbfr_pkg::STATUS_OK;
      if (!avail) begin
         ext_value = '0;
         ext_status = lbfr_pkg::STATUS_OVERRUN;
      end else begin
         case (kind_ff)
            lbfr_pkg::KIND_PREFIXED: begin
               if (step_ff == '0) begin
                  done = (field[5:4] == 2'b00);
               end else begin
                  ext_value = {field[DW-5:0], head_ff[3:0]};
               end
            end
            lbfr_pkg::KIND_VARINT: begin
               ext_value = value_ff | ({25'd0, field[6:0]} << lbfr_pkg::varint_shift(step_ff));
               if (field[7]) begin
                  if (step_ff == lbfr_pkg::VARINT_LAST_STEP) begin
                     ext_value = '1;
                     ext_status = lbfr_pkg::STATUS_TOO_LONG;
                  end else begin
                     done = 1'b0;
                  end
               end
            end
            default: ext_value = field;
         endcase
      end
   end

   always_comb begin
      kind_in = kind_ff;
      cnt_in = cnt_ff;
      step_in = step_ff;
      head_in = head_ff;
      tp_in = tp_ff;
      pos_in = pos_ff;
      words_in = words_ff;
      value_in = value_ff;
      status_in = status_ff;
      if (wr_en) begin
         words_in = words_ff + WB'(1);
      end
      if (cmd.start) begin
         kind_in = req_kind;
         cnt_in = (req_count > lbfr_pkg::MAX_FIELD_BITS) ? lbfr_pkg::MAX_FIELD_BITS : req_count;
         step_in = '0;
         tp_in = pos_ff;
         value_in = '0;
         status_in = lbfr_pkg::STATUS_OK;
      end
      if (cmd.extract) begin
         value_in = ext_value;
         status_in = ext_status;
         step_in = step_ff + lbfr_pkg::STEP_BITS'(1);
         if (step_ff == '0) begin
            head_in = field[lbfr_pkg::HEAD_BITS-1:0];
         end
         if (avail) begin
            tp_in = tp_next;
            if (done) begin
               pos_in = tp_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         tp_ff <= '0;
         words_ff <= '0;
         step_ff <= '0;
         value_ff <= '0;
         status_ff <= lbfr_pkg::STATUS_OK;
      end else begin
         pos_ff <= pos_in;
         tp_ff <= tp_in;
         words_ff <= words_in;
         step_ff <= step_in;
         value_ff <= value_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      cnt_ff <= cnt_in;
      head_ff <= head_in;
   end

   assign sts.is_load = (req_kind == lbfr_pkg::KIND_LOAD);
   assign sts.done = done;
   assign rsp_value = value_ff;
   assign rsp_status = status_ff;

   `LBFR_ASSERT_SAME(a_pos_within_loaded, clock, reset, 1'b1, (pos_ff <= loaded) && (tp_ff <= loaded), "read position passed the loaded bits")
   `LBFR_ASSERT_SAME(a_words_bounded, clock, reset, 1'b1, words_ff <= WB'(STORE_WORDS), "word count exceeds the store depth")
   `LBFR_ASSERT_SAME(a_overrun_zero, clock, reset, status_ff == lbfr_pkg::STATUS_OVERRUN, value_ff == '0, "overrun result carries a nonzero value")

endmodule

>>> design/lbfr_controller.sv
`include "lsb_first_bit_field_reader_assert.svh"

module lbfr_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  lbfr_pkg::sts_type sts,
   output lbfr_pkg::cmd_type cmd
);

   lbfr_pkg::state_type state_ff, state_in;
   logic accept;

   assign accept = req_valid && (state_ff == lbfr_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbfr_pkg::ST_IDLE: begin
            if (req_valid && !sts.is_load) begin
               state_in = lbfr_pkg::ST_FETCH;
            end
         end
         lbfr_pkg::ST_FETCH: state_in = lbfr_pkg::ST_EXTRACT;
         lbfr_pkg::ST_EXTRACT: begin
            state_in = sts.done ? lbfr_pkg::ST_RESPOND : lbfr_pkg::ST_FETCH;
         end
         lbfr_pkg::ST_RESPOND: begin
            if (rsp_ready) begin
               state_in = lbfr_pkg::ST_IDLE;
            end
         end
         default: state_in = lbfr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      case (state_ff)
         lbfr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = accept && !sts.is_load;
            cmd.load = accept && sts.is_load;
         end
         lbfr_pkg::ST_FETCH: cmd.fetch = 1'b1;
         lbfr_pkg::ST_EXTRACT: cmd.extract = 1'b1;
         lbfr_pkg::ST_RESPOND: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LBFR_ASSERT_NEXT(a_read_starts, clock, reset, accept && !sts.is_load, state_ff == lbfr_pkg::ST_FETCH, "accepted read did not start a fetch")
   `LBFR_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, state_ff == lbfr_pkg::ST_RESPOND, "result dropped before it was taken")

endmodule

>>> design/lsb_first_bit_field_reader.sv
// LSB-first bit field reader.
// The req channel carries one beat per item: kind selects a word load, a plain
// field read of count bits, a prefixed variable field read or a varint read.
// Load beats append word to the store until it is full and give no rsp beat;
// each read beat gives exactly one rsp beat with value and status.
// A load leaves the controller idle, and the next beat may follow at once.
// Each field fetch has a fetch state, which reads two adjacent store words
// through the dual read port of the store RAM, and an extract state, which
// aligns and masks them. A plain read takes one field fetch, a prefixed read
// one or two, and a varint one per byte, at most five.
// One item is in flight at a time; req_bus.ready is low until the rsp beat
// is taken.
// When the receiver stalls, the rsp beat holds its payload and no further
// req beat is taken.
// Reset empties the store and zeroes the read position; no clearing pass is
// needed, since only loaded words are ever read.
module lsb_first_bit_field_reader #(
   parameter int STORE_WORDS = lbfr_pkg::STORE_WORDS_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   lbfr_req_if.sink   req_bus,
   lbfr_rsp_if.source rsp_bus
);

   lbfr_pkg::cmd_type cmd;
   lbfr_pkg::sts_type sts;

   lbfr_controller u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   lbfr_datapath #(
      .STORE_WORDS(STORE_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_kind  (req_bus.kind),
      .req_word  (req_bus.word),
      .req_count (req_bus.count),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_value (rsp_bus.value),
      .rsp_status(rsp_bus.status)
   );

endmodule

>>> verif/lsb_first_bit_field_reader_tb.sv
module lsb_first_bit_field_reader_tb;

   localparam int STORE_DEPTH = lbfr_pkg::STORE_WORDS_DEFAULT;
   localparam int DW = lbfr_pkg::WORD_BITS;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [lbfr_pkg::WORD_BITS-1:0] value;
      logic [lbfr_pkg::STATUS_BITS-1:0] status;
   } field_result_type;

   typedef struct packed {
      logic [lbfr_pkg::KIND_BITS-1:0] kind;
      logic [lbfr_pkg::WORD_BITS-1:0] word;
      logic [lbfr_pkg::COUNT_BITS-1:0] count;
      logic typed;
      logic [lbfr_pkg::WORD_BITS-1:0] value;
      logic [lbfr_pkg::STATUS_BITS-1:0] status;
   } script_row_type;

   logic clock;
   logic reset;

   lbfr_req_if req_bus();
   lbfr_rsp_if rsp_bus();

   lsb_first_bit_field_reader #(
      .STORE_WORDS(STORE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic [DW-1:0] store_model [STORE_DEPTH];
   int unsigned filled_bits = 0;
   int unsigned cursor = 0;
   field_result_type pending_fields [$];
   field_result_type expected_field;
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 1;
   int rx_run = 0;
   logic rx_level = 1'b0;

   script_row_type directed_rows [25] = '{
      '{lbfr_pkg::KIND_BITS_FIELD, 32'h0, 6'd1, 1'b1, 32'h0, lbfr_pkg::STATUS_OVERRUN},
      '{lbfr_pkg::KIND_PREFIXED, 32'h0, 6'd0, 1'b1, 32'h0, lbfr_pkg::STATUS_OVERRUN},
      '{lbfr_pkg::KIND_VARINT, 32'h0, 6'd0, 1'b1, 32'h0, lbfr_pkg::STATUS_OVERRUN},
      '{lbfr_pkg::KIND_BITS_FIELD, 32'h0, 6'd0, 1'b1, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_LOAD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_BITS_FIELD, 32'h0, 6'd32, 1'b1, 32'hFFFF_FFFF, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_BITS_FIELD, 32'h0, 6'd33, 1'b1, 32'h0, lbfr_pkg::STATUS_OVERRUN},
      '{lbfr_pkg::KIND_LOAD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_LOAD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_VARINT, 32'h0, 6'd0, 1'b1, 32'hFFFF_FFFF, lbfr_pkg::STATUS_TOO_LONG},
      '{lbfr_pkg::KIND_LOAD, 32'h0, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_BITS_FIELD, 32'h0, 6'd63, 1'b1, 32'h00FF_FFFF, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_PREFIXED, 32'h0, 6'd0, 1'b1, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_BITS_FIELD, 32'h0, 6'd18, 1'b1, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_LOAD, 32'h969E_971A, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_PREFIXED, 32'h0, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_PREFIXED, 32'h0, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_LOAD, 32'hABCD_3701, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_VARINT, 32'h0, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_PREFIXED, 32'h0, 6'd0, 1'b1, 32'h0, lbfr_pkg::STATUS_OVERRUN},
      '{lbfr_pkg::KIND_LOAD, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_PREFIXED, 32'h0, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_VARINT, 32'h0, 6'd0, 1'b1, 32'h0, lbfr_pkg::STATUS_OVERRUN},
      '{lbfr_pkg::KIND_LOAD, 32'h0, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK},
      '{lbfr_pkg::KIND_VARINT, 32'h0, 6'd0, 1'b0, 32'h0, lbfr_pkg::STATUS_OK}
   };

   initial clock = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic take_field(inout int unsigned pos, input int unsigned width,
                                       output logic [DW-1:0] field);
      logic [2*DW-1:0] both;
      logic [2*DW-1:0] window;
      int unsigned first;
      int unsigned last;
      field = '0;
      if (pos > filled_bits || width > filled_bits - pos) begin
         return 1'b0;
      end
      first = pos / DW;
      last = (pos + width - 1) / DW;
      both = {(last != first) ? store_model[last] : {DW{1'b0}}, store_model[first]};
      window = (both >> (pos % DW)) & ((64'd1 << width) - 64'd1);
      field = window[DW-1:0];
      pos = pos + width;
      return 1'b1;
   endfunction

   function automatic void decode_item(input logic [lbfr_pkg::KIND_BITS-1:0] kind,
                                       input logic [DW-1:0] word,
                                       input logic [lbfr_pkg::COUNT_BITS-1:0] count,
                                       output logic has_rsp,
                                       output field_result_type outcome);
      int unsigned pos;
      int unsigned width;
      logic [DW-1:0] value;
      logic [DW-1:0] head;
      logic [DW-1:0] ext;
      logic [DW-1:0] octet;
      logic [lbfr_pkg::STATUS_BITS-1:0] status;
      logic ok;
      logic more;
      pos = cursor;
      value = '0;
      status = lbfr_pkg::STATUS_OK;
      ok = 1'b1;
      has_rsp = 1'b1;
      case (kind)
         lbfr_pkg::KIND_LOAD: begin
            has_rsp = 1'b0;
            if (filled_bits / DW < STORE_DEPTH) begin
               store_model[filled_bits / DW] = word;
               filled_bits = filled_bits + DW;
            end
         end
         lbfr_pkg::KIND_BITS_FIELD: begin
            width = (count > lbfr_pkg::MAX_FIELD_BITS) ? 32'(lbfr_pkg::MAX_FIELD_BITS)
                                                       : 32'(count);
            if (width != 0) begin
               ok = take_field(pos, width, value);
            end
         end
         lbfr_pkg::KIND_PREFIXED: begin
            ok = take_field(pos, 32'(lbfr_pkg::HEAD_FIELD_BITS), head);
            if (ok) begin
               value = head;
               if (head[5:4] != 2'd0) begin
                  width = (head[5:4] == 2'd1) ? 4 : (head[5:4] == 2'd2) ? 8 : 28;
                  ok = take_field(pos, width, ext);
                  value = (head & 32'h0000_000F) | (ext << 4);
               end
            end
         end
         lbfr_pkg::KIND_VARINT: begin
            more = 1'b1;
            for (int i = 0; i < 5 && more && ok; i++) begin
               ok = take_field(pos, 32'(lbfr_pkg::BYTE_FIELD_BITS), octet);
               if (ok) begin
                  value = value | ((octet & 32'h0000_007F) << (7 * i));
                  more = octet[7];
               end
            end
            if (ok && more) begin
               value = '1;
               status = lbfr_pkg::STATUS_TOO_LONG;
            end
         end
         default: has_rsp = 1'b0;
      endcase
      if (!ok) begin
         value = '0;
         status = lbfr_pkg::STATUS_OVERRUN;
      end else begin
         cursor = pos;
      end
      outcome = '{value, status};
   endfunction

   task wait_drained;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_fields.size() != 0);
   endtask

   task automatic send_beat(input logic [lbfr_pkg::KIND_BITS-1:0] kind,
                            input logic [DW-1:0] word,
                            input logic [lbfr_pkg::COUNT_BITS-1:0] count,
                            input logic typed,
                            input logic [DW-1:0] typed_value,
                            input logic [lbfr_pkg::STATUS_BITS-1:0] typed_status);
      field_result_type predicted;
      logic has_rsp;
      int gap;
      req_bus.kind <= kind;
      req_bus.word <= word;
      req_bus.count <= count;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      decode_item(kind, word, count, has_rsp, predicted);
      if (has_rsp) begin
         pending_fields.push_back(typed ? field_result_type'{typed_value, typed_status}
                                        : predicted);
      end
      burst_left--;
      if ($urandom_range(0, 149) == 0) begin
         wait_drained();
      end else if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_random(input int load_pct, input logic wide_reads);
      logic [lbfr_pkg::KIND_BITS-1:0] kind;
      logic [DW-1:0] word;
      logic [lbfr_pkg::COUNT_BITS-1:0] count;
      logic [31:0] rnd;
      int pick;
      word = $urandom;
      rnd = $urandom;
      count = rnd[lbfr_pkg::COUNT_BITS-1:0];
      if ($urandom_range(1, 100) <= load_pct) begin
         kind = lbfr_pkg::KIND_LOAD;
         if ($urandom_range(0, 5) == 0) begin
            word = word | 32'h8080_8080;
         end
      end else begin
         case ($urandom_range(0, 2))
            0: kind = lbfr_pkg::KIND_BITS_FIELD;
            1: kind = lbfr_pkg::KIND_PREFIXED;
            default: kind = lbfr_pkg::KIND_VARINT;
         endcase
         if (wide_reads && $urandom_range(0, 1) == 0) begin
            kind = lbfr_pkg::KIND_BITS_FIELD;
         end
         if (kind == lbfr_pkg::KIND_BITS_FIELD) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               count = '0;
            end else if (pick < 3) begin
               rnd = $urandom_range(33, 63);
               count = rnd[lbfr_pkg::COUNT_BITS-1:0];
            end else if (pick < 6 || wide_reads) begin
               count = lbfr_pkg::MAX_FIELD_BITS;
            end else begin
               rnd = $urandom_range(1, 31);
               count = rnd[lbfr_pkg::COUNT_BITS-1:0];
            end
         end
      end
      send_beat(kind, word, count, 1'b0, '0, lbfr_pkg::STATUS_OK);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = lbfr_pkg::KIND_LOAD;
      req_bus.word = '0;
      req_bus.count = '0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].count,
                   directed_rows[i].typed, directed_rows[i].value, directed_rows[i].status);
      end
      wait_drained();

      // Keep the unread window short so that overruns and boundary crossings stay common.
      repeat (150) begin
         send_random((filled_bits - cursor < 48) ? 65 : 25, 1'b0);
      end
      wait_drained();

      while (filled_bits < STORE_DEPTH * DW) begin
         send_random(95, 1'b1);
      end
      repeat (8) send_random(100, 1'b0);
      wait_drained();

      repeat (100) send_random(8, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (rx_run <= 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rx_level = 1'b1;
               rx_run = $urandom_range(20, 60);
            end
            1: begin
               rx_level = 1'b0;
               rx_run = $urandom_range(1, 12);
            end
            default: begin
               rx_level = ~rx_level;
               rx_run = $urandom_range(1, 4);
            end
         endcase
      end
      rx_run = rx_run - 1;
      rsp_bus.ready <= rx_level;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         if (pending_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected rsp beat: value %h status %0d", rsp_bus.value,
                        rsp_bus.status);
            end
         end else begin
            expected_field = pending_fields.pop_front();
            if (rsp_bus.value !== expected_field.value ||
                rsp_bus.status !== expected_field.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("rsp mismatch: expected value %h status %0d, got value %h status %0d",
                           expected_field.value, expected_field.status, rsp_bus.value,
                           rsp_bus.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> files.f
+incdir+design
design/lbfr_pkg.sv
design/lbfr_if.sv
design/lbfr_ram.sv
design/lbfr_datapath.sv
design/lbfr_controller.sv
design/lsb_first_bit_field_reader.sv
verif/lsb_first_bit_field_reader_tb.sv
